// ===== hw/rtl/mvsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mvsa_pkg
// Shared types and constants for the MIDI voice slot allocator.
// ----------------------------------------------------------------------------
package mvsa_pkg;

  localparam int VOICE_SLOTS = 16;
  localparam int SLOT_W      = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int NOTE_W      = 7;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HARM_CHAN   = 2'd0;
  localparam logic [1:0] REG_CTRL_CHAN   = 2'd1;
  localparam logic [1:0] REG_CUR_PRESET  = 2'd2;
  localparam logic [1:0] REG_LEARN_MODE  = 2'd3;
  localparam int         CFG_ADDR_W      = 4;

  // MIDI message types (upper nibble of the status byte)
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CONTROL  = 4'hB;
  localparam logic [3:0] MSG_PROGRAM  = 4'hC;

  // Program change codes and preset range
  localparam logic [6:0] PROG_STEP_DOWN = 7'd81;
  localparam logic [6:0] PROG_STEP_UP   = 7'd82;
  localparam logic [5:0] PRESET_MIN     = 6'd1;
  localparam logic [5:0] PRESET_MAX     = 6'd60;

  // Event kinds
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_VOICE_ON  = 3'd1;
  localparam logic [2:0] EV_VOICE_OFF = 3'd2;
  localparam logic [2:0] EV_PRESET    = 3'd3;
  localparam logic [2:0] EV_CTRL      = 3'd4;
  localparam logic [2:0] EV_LEARN     = 3'd5;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } msg_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  slot_index;
    logic [6:0]  note_number;
    logic [15:0] gate_mask;
    logic        chord_update;
    logic [5:0]  preset_value;
    logic [6:0]  controller_number;
    logic [6:0]  controller_value;
  } result_item_t;

endpackage

// ===== hw/rtl/midi_voice_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// midi_voice_slot_allocator
// Takes one MIDI message per item, allocates or releases voice slots and
// decodes program change and controller messages into one result item.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -------------------------
//  message   in         start & !busy             msg_item_t
//  result    out        done (one-cycle strobe)   result_item_t
//  config    in         APB: psel&penable&pwrite  4 regs at paddr 4*i
//
//  Timing: a note-on, program change, controller or ignored message gives
//  its result in the cycle after it is taken. A release scans the note RAM
//  one slot per cycle through its single read port and stops at the first
//  active slot holding the note, or at the last slot if none holds it.
//  Reset clears the active/gate bits and the config registers at once; the
//  note RAM needs no clearing since only active slots are read.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
module midi_voice_slot_allocator
  import mvsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // message channel
  input  logic                  start,
  output logic                  busy,
  input  msg_item_t             message,
  // result channel
  output logic                  done,
  output result_item_t          result,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(VOICE_SLOTS - 1);

  // Configuration registers
  logic [3:0] harm_chan;
  logic [3:0] ctrl_chan;
  logic [5:0] cur_preset;
  logic       learn_mode;

  // Control state
  state_t                 state, state_next;
  logic [SLOT_W-1:0]      scan_idx, scan_idx_next;
  logic [NOTE_W-1:0]      note_key, note_key_next;
  logic [VOICE_SLOTS-1:0] active, active_next;   // active == gate for every slot
  logic                   done_next;
  result_item_t           result_next;

  // Note RAM ports
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [NOTE_W-1:0]      ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [NOTE_W-1:0]      ram_rdata;

  // Decode
  logic [3:0]             msg_type;
  logic [3:0]             msg_chan;
  logic                   accept;
  logic                   is_on, is_off, is_prog, is_ctrl, is_note;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic                   scan_hit;
  logic [5:0]             preset_dn;
  logic [5:0]             preset_up;
  logic                   cfg_wr;
  result_item_t           res;
  logic                   load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      harm_chan  <= 4'd0;
      ctrl_chan  <= 4'd0;
      cur_preset <= PRESET_MIN;
      learn_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HARM_CHAN:  harm_chan  <= pwdata[3:0];
        REG_CTRL_CHAN:  ctrl_chan  <= pwdata[3:0];
        REG_CUR_PRESET: cur_preset <= pwdata[5:0];
        REG_LEARN_MODE: learn_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HARM_CHAN:  prdata = {28'd0, harm_chan};
      REG_CTRL_CHAN:  prdata = {28'd0, ctrl_chan};
      REG_CUR_PRESET: prdata = {26'd0, cur_preset};
      REG_LEARN_MODE: prdata = {31'd0, learn_mode};
      default:        prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Note store: one entry per slot, read during release scans
  // --------------------------------------------------------------------------
  mvsa_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (VOICE_SLOTS)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read slot 0 while idle so its note is ready on the first scan cycle;
  // during the scan, prefetch the next slot.
  assign ram_raddr = (state == ST_SCAN) ? scan_idx + SLOT_W'(1) : '0;

  // --------------------------------------------------------------------------
  // Message decode
  // --------------------------------------------------------------------------
  always_comb begin
    msg_type = message.status_byte[7:4];
    msg_chan = message.status_byte[3:0];
    is_note  = ((msg_type == MSG_NOTE_ON) || (msg_type == MSG_NOTE_OFF)) &&
               (msg_chan == harm_chan);
    is_on    = is_note && (msg_type == MSG_NOTE_ON) && (message.data_second != 7'd0);
    is_off   = is_note && !is_on;
    is_prog  = (msg_type == MSG_PROGRAM) && (msg_chan == ctrl_chan);
    is_ctrl  = (msg_type == MSG_CONTROL) && (msg_chan == ctrl_chan);
    preset_dn = cur_preset - 6'd1;
    preset_up = cur_preset + 6'd1;
  end

  // First free slot: lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Registered RAM data belongs to scan_idx while scanning
  assign scan_hit = active[scan_idx] && (ram_rdata == note_key);

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    note_key_next = note_key;
    active_next   = active;
    ram_we        = 1'b0;
    ram_waddr     = free_idx;
    ram_wdata     = message.data_first;
    res           = '0;
    load          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_off) begin
            // Hand off to the release scan; no result yet
            note_key_next = message.data_first;
            scan_idx_next = '0;
            state_next    = ST_SCAN;
          end else begin
            load = 1'b1;
            if (is_on) begin
              if (free_found) begin
                ram_we                = 1'b1;
                active_next[free_idx] = 1'b1;
                res.event_kind        = EV_VOICE_ON;
                res.slot_index        = 4'(free_idx);
                res.note_number       = message.data_first;
                res.chord_update      = 1'b1;
              end
            end else if (is_prog) begin
              if ((message.data_first >= 7'(PRESET_MIN)) &&
                  (message.data_first <= 7'(PRESET_MAX))) begin
                res.event_kind   = EV_PRESET;
                res.preset_value = message.data_first[5:0];
              end else if ((message.data_first == PROG_STEP_DOWN) &&
                           (cur_preset > PRESET_MIN)) begin
                // Clamp when the register holds a value above the range
                res.event_kind   = EV_PRESET;
                res.preset_value = (preset_dn > PRESET_MAX) ? PRESET_MAX : preset_dn;
              end else if ((message.data_first == PROG_STEP_UP) &&
                           (cur_preset < PRESET_MAX)) begin
                res.event_kind   = EV_PRESET;
                res.preset_value = preset_up;
              end
            end else if (is_ctrl) begin
              res.controller_number = message.data_first;
              if (learn_mode) begin
                res.event_kind = EV_LEARN;
              end else begin
                res.event_kind       = EV_CTRL;
                res.controller_value = message.data_second;
              end
            end
          end
        end
      end

      ST_SCAN: begin
        if (scan_hit) begin
          active_next[scan_idx] = 1'b0;
          res.event_kind        = EV_VOICE_OFF;
          res.slot_index        = 4'(scan_idx);
          res.note_number       = note_key;
          load                  = 1'b1;
          state_next            = ST_IDLE;
        end else if (scan_idx == SLOT_LAST) begin
          // Note not held: report an EV_NONE result
          load       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + SLOT_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.gate_mask = 16'(active_next);
    done_next     = load;
    result_next   = load ? res : result;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      active <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
      done   <= done_next;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    note_key <= note_key_next;
    result   <= result_next;
  end

endmodule

// ===== hw/rtl/mvsa_ram.sv =====
// ----------------------------------------------------------------------------
// mvsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mvsa_checker.sv =====
// ----------------------------------------------------------------------------
// mvsa_checker
// Port-level checks for the MIDI voice slot allocator.
// ----------------------------------------------------------------------------
module mvsa_checker
  import mvsa_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input result_item_t          result
);

  // A taken item either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted item neither answered nor held busy");

  // A result is only shown once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A claimed slot shows its gate raised and asks for a chord update
  a_voice_on_gate: assert property (@(posedge clk) disable iff (rst)
    done && (result.event_kind == EV_VOICE_ON) |->
      result.gate_mask[result.slot_index] && result.chord_update)
    else $error("voice on without gate or chord update");

  // A freed slot shows its gate dropped
  a_voice_off_gate: assert property (@(posedge clk) disable iff (rst)
    done && (result.event_kind == EV_VOICE_OFF) |->
      !result.gate_mask[result.slot_index] && !result.chord_update)
    else $error("voice off with gate still set");

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("block not idle after reset");

endmodule

bind midi_voice_slot_allocator mvsa_checker u_mvsa_checker (.*);
